// ===== src/srrb_pkg.sv =====
`timescale 1ns / 1ps

package srrb_pkg;

   // Window geometry.
   localparam int WINDOW_DEPTH = 32;
   localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
   localparam int PTR_W        = $clog2(WINDOW_DEPTH + 1);

   // Fixed field widths.
   localparam int SEQ_W  = 5;
   localparam int DATA_W = 64;
   localparam int KIND_W = 2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEW_ACK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DUP_ACK = 2'd3;

   // One result word.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  ack_seq;
      logic [DATA_W-1:0] delivered;
      logic              last;
   } rsp_type;

   // Write port of the payload store.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } ram_wr_type;

endpackage

// ===== src/srrb_payload_ram.sv =====
`timescale 1ns / 1ps

module srrb_payload_ram (
   input  logic                        clock,
   input  srrb_pkg::ram_wr_type        wr,
   input  logic [srrb_pkg::SLOT_W-1:0] rd_addr,
   output logic [srrb_pkg::DATA_W-1:0] rd_data
);

   logic [srrb_pkg::DATA_W-1:0] mem_ff [srrb_pkg::WINDOW_DEPTH];
   logic [srrb_pkg::DATA_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Registered read; the data follows the address in the next cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/srrb_rsp_reg.sv =====
`timescale 1ns / 1ps

module srrb_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  srrb_pkg::rsp_type load_data,
   output logic              free,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output srrb_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   srrb_pkg::rsp_type data_ff;

   // The register can take a new word when empty or when its word leaves now.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== src/selective_repeat_receive_buffer.sv =====
`timescale 1ns / 1ps
// A packet is taken only while the sequencer is idle; its first result word is loaded into
// the output register from ST_FIRST. A packet with a bad checksum gets no result word. After
// a store that lets the delivery pointer move, ST_READ reads the payload memory and ST_DELIVER
// releases n payloads, one per cycle while rsp_ready takes each word; a held word stalls it.
// Reset (synchronous, active high) clears the filled and acked marks and the delivery
// pointer at once; the payload memory is not cleared and needs no clearing pass.
module selective_repeat_receive_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_checksum_ok,
   input  logic                                req_is_ack,
   input  logic [srrb_pkg::SEQ_W-1:0]          req_seq_number,
   input  logic [srrb_pkg::SEQ_W-1:0]          req_acked_number,
   input  logic [srrb_pkg::DATA_W-1:0]         req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [srrb_pkg::KIND_W-1:0]         rsp_kind,
   output logic [srrb_pkg::SEQ_W-1:0]          rsp_ack_seq,
   output logic [srrb_pkg::DATA_W-1:0]         rsp_delivered,
   output logic                                rsp_last
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_FIRST   = 2'd1;
   localparam logic [1:0] ST_READ    = 2'd2;
   localparam logic [1:0] ST_DELIVER = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [srrb_pkg::PTR_W-1:0] ntd_ff;
   logic [srrb_pkg::PTR_W-1:0] ntd_in;
   logic [srrb_pkg::WINDOW_DEPTH-1:0] filled_ff;
   logic [srrb_pkg::WINDOW_DEPTH-1:0] filled_in;
   logic [srrb_pkg::WINDOW_DEPTH-1:0] seen_ff;
   logic [srrb_pkg::WINDOW_DEPTH-1:0] seen_in;

   // Latched packet.
   logic                        is_ack_ff;
   logic [srrb_pkg::SEQ_W-1:0]  seq_ff;
   logic [srrb_pkg::SEQ_W-1:0]  acked_ff;
   logic [srrb_pkg::DATA_W-1:0] payload_ff;

   logic                         accept;
   logic                         out_free;
   logic                         load;
   srrb_pkg::rsp_type            result;
   srrb_pkg::rsp_type            rsp_word;
   srrb_pkg::ram_wr_type         wr;
   logic [srrb_pkg::SLOT_W-1:0]  rd_addr;
   logic [srrb_pkg::DATA_W-1:0]  rd_data;

   logic [srrb_pkg::SLOT_W-1:0]  seq_idx;
   logic [srrb_pkg::SLOT_W-1:0]  acked_idx;
   logic [srrb_pkg::SLOT_W-1:0]  ntd_idx;
   logic [srrb_pkg::PTR_W-1:0]   ntd_nxt;
   logic [srrb_pkg::SLOT_W-1:0]  ntd_nxt_idx;
   logic                         ntd_open;
   logic                         ack_new;
   logic                         store;
   logic                         walk;
   logic                         more;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Slot lookups for the latched packet and the delivery pointer.
   assign seq_idx     = srrb_pkg::SLOT_W'(seq_ff);
   assign acked_idx   = srrb_pkg::SLOT_W'(acked_ff);
   assign ntd_idx     = srrb_pkg::SLOT_W'(ntd_ff);
   assign ntd_nxt     = ntd_ff + srrb_pkg::PTR_W'(1);
   assign ntd_nxt_idx = srrb_pkg::SLOT_W'(ntd_nxt);
   assign ntd_open    = ntd_ff < srrb_pkg::PTR_W'(srrb_pkg::WINDOW_DEPTH);

   assign ack_new = (32'(acked_ff) < 32'(srrb_pkg::WINDOW_DEPTH)) && !seen_ff[acked_idx];
   assign store   = (32'(seq_ff) < 32'(srrb_pkg::WINDOW_DEPTH)) && !filled_ff[seq_idx];
   assign walk    = store && ntd_open && (filled_ff[ntd_idx] || (ntd_idx == seq_idx));
   assign more    = (ntd_nxt < srrb_pkg::PTR_W'(srrb_pkg::WINDOW_DEPTH))
                    && filled_ff[ntd_nxt_idx];

   // Sequencer: first word (ack or ack report), then the in-order release walk.
   always_comb begin
      state_in  = state_ff;
      ntd_in    = ntd_ff;
      filled_in = filled_ff;
      seen_in   = seen_ff;
      load      = 1'b0;
      result    = '0;
      wr        = '0;
      rd_addr   = ntd_idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_checksum_ok) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (out_free) begin
               load        = 1'b1;
               result.last = 1'b1;
               if (is_ack_ff) begin
                  result.kind    = ack_new ? srrb_pkg::KIND_NEW_ACK : srrb_pkg::KIND_DUP_ACK;
                  result.ack_seq = acked_ff;
                  if (ack_new) begin
                     seen_in[acked_idx] = 1'b1;
                  end
                  state_in = ST_IDLE;
               end else begin
                  result.kind    = srrb_pkg::KIND_ACK;
                  result.ack_seq = seq_ff;
                  result.last    = !walk;
                  if (store) begin
                     filled_in[seq_idx] = 1'b1;
                     wr.en   = 1'b1;
                     wr.addr = seq_idx;
                     wr.data = payload_ff;
                  end
                  state_in = walk ? ST_READ : ST_IDLE;
               end
            end
         end
         ST_READ: begin
            // The pointer's slot is read now, after the new payload is written.
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_free) begin
               load             = 1'b1;
               result.kind      = srrb_pkg::KIND_DELIVER;
               result.ack_seq   = srrb_pkg::SEQ_W'(ntd_ff);
               result.delivered = rd_data;
               result.last      = !more;
               ntd_in           = ntd_nxt;
               if (more) begin
                  rd_addr = ntd_nxt_idx;
               end
               state_in = more ? ST_DELIVER : ST_IDLE;
            end
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ntd_ff    <= '0;
         filled_ff <= '0;
         seen_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ntd_ff    <= ntd_in;
         filled_ff <= filled_in;
         seen_ff   <= seen_in;
      end
   end

   // Input word capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         is_ack_ff  <= req_is_ack;
         seq_ff     <= req_seq_number;
         acked_ff   <= req_acked_number;
         payload_ff <= req_payload;
      end
   end

   srrb_payload_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srrb_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (result),
      .free      (out_free),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_word)
   );

   assign rsp_kind      = rsp_word.kind;
   assign rsp_ack_seq   = rsp_word.ack_seq;
   assign rsp_delivered = rsp_word.delivered;
   assign rsp_last      = rsp_word.last;

   // The delivery pointer never passes the window end.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ntd_ff <= srrb_pkg::PTR_W'(srrb_pkg::WINDOW_DEPTH))
      else $error("delivery pointer beyond window end");

   // The walk only visits filled slots inside the window.
   a_walk_filled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELIVER) |-> (ntd_open && filled_ff[ntd_idx]))
      else $error("release walk on an empty slot");

   // A good packet always moves on to its first result word.
   a_good_first: assert property (@(posedge clock) disable iff (reset)
      (accept && req_checksum_ok) |=> (state_ff == ST_FIRST))
      else $error("accepted packet lost");

   // A delivered word always advances the pointer by one.
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      (load && result.kind == srrb_pkg::KIND_DELIVER) |=> (ntd_ff == $past(ntd_nxt)))
      else $error("pointer did not advance on delivery");

endmodule
